// ----- rtl/core/ispd_pkg.sv -----
// shared constants and types for the imu serial packet decoder
// no dependencies
package ispd_pkg;

	localparam int PACKET_BYTES = 11;
	localparam int COUNT_W      = $clog2(PACKET_BYTES);
	localparam int STORE_DEPTH  = PACKET_BYTES - 1;
	localparam int IDX_W        = $clog2(STORE_DEPTH);

	localparam int AXIS_W = 28;
	localparam int TEMP_W = 25;
	localparam int RAW_W  = 16;

	// byte positions inside a packet
	localparam int POS_TYPE = 1;
	localparam int POS_X    = 2;
	localparam int POS_Y    = 4;
	localparam int POS_Z    = 6;
	localparam int POS_TEMP = 8;

	// register indexes
	localparam logic [1:0] REG_START_BYTE = 2'd0;
	localparam logic [1:0] REG_ACCEL_TYPE = 2'd1;
	localparam logic [1:0] REG_GYRO_TYPE  = 2'd2;
	localparam logic [1:0] REG_ANGLE_TYPE = 2'd3;

	localparam logic [7:0] START_BYTE_RST = 8'd85;
	localparam logic [7:0] ACCEL_TYPE_RST = 8'd81;
	localparam logic [7:0] GYRO_TYPE_RST  = 8'd82;
	localparam logic [7:0] ANGLE_TYPE_RST = 8'd83;

	// full scale over 32768, in q16.16
	localparam logic signed [AXIS_W-1:0] SCALE_ACCEL = 28'sd32;
	localparam logic signed [AXIS_W-1:0] SCALE_GYRO  = 28'sd4000;
	localparam logic signed [AXIS_W-1:0] SCALE_ANGLE = 28'sd360;

	// temperature: round(raw * 16384 / 85) + 36.25 * 65536
	localparam int          TEMP_SHIFT  = 14;
	localparam int          TEMP_NUM_W  = 30;
	localparam int          TEMP_DIV    = 85;
	localparam logic [TEMP_NUM_W-1:0] TEMP_HALF = 30'd42;
	localparam int          RECIP_SHIFT = 38;
	localparam logic [31:0] RECIP_85    = 32'd3233857729;
	localparam int          QUOT_W      = 24;
	localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 25'sd2375680;

	typedef enum logic [1:0] {
		SCALE_NONE,
		SCALE_SEL_ACCEL,
		SCALE_SEL_GYRO,
		SCALE_SEL_ANGLE
	} scale_sel_t;

endpackage

// ----- rtl/core/imu_serial_packet_decoder.sv -----
// imu serial packet decoder top level: framing, checksum and scaling
// depends on ispd_pkg
//
// One received byte is taken per beat, every cycle while in_stall is low,
// with no gaps needed between bytes. Each byte only updates the frame count,
// running sum and byte store, so framing runs at one byte per cycle when not
// stalled. When the checksum byte of a packet matches, the packet fields go
// to a stage register and the scaled result then moves to the output
// register, whose contents form the result beat. The input stalls only
// when a result waits in the output register and another waits in the stage
// register behind it. Configuration registers sit on the APB port at byte
// address 4*i: start_byte, accel_type, gyro_type, angle_type.
module imu_serial_packet_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [3:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       packet_type,
	output logic signed [ispd_pkg::AXIS_W-1:0] axis_x,
	output logic signed [ispd_pkg::AXIS_W-1:0] axis_y,
	output logic signed [ispd_pkg::AXIS_W-1:0] axis_z,
	output logic signed [ispd_pkg::TEMP_W-1:0] temperature
);
	import ispd_pkg::*;

	logic [7:0] start_byte_q, accel_type_q, gyro_type_q, angle_type_q;

	logic [7:0]         store_q [STORE_DEPTH];
	logic [COUNT_W-1:0] count_q;
	logic               active_q;
	logic [7:0]         sum_q;

	logic                    v_s1;
	logic [7:0]              type_s1;
	scale_sel_t              sel_s1;
	logic signed [RAW_W-1:0] raw_x_s1, raw_y_s1, raw_z_s1, raw_t_s1;

	logic out_valid_q;

	logic               in_accept, is_start, active_now, is_final, match, load_s1;
	logic               out_free, move_s1;
	logic [COUNT_W-1:0] base_count;
	logic [7:0]         base_sum;
	logic [1:0]         reg_idx;
	logic               cfg_write;
	scale_sel_t         sel_now;

	// config port
	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			accel_type_q <= ACCEL_TYPE_RST;
			gyro_type_q  <= GYRO_TYPE_RST;
			angle_type_q <= ANGLE_TYPE_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_START_BYTE: start_byte_q <= pwdata[7:0];
				REG_ACCEL_TYPE: accel_type_q <= pwdata[7:0];
				REG_GYRO_TYPE:  gyro_type_q  <= pwdata[7:0];
				REG_ANGLE_TYPE: angle_type_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_BYTE: prdata = {24'd0, start_byte_q};
			REG_ACCEL_TYPE: prdata = {24'd0, accel_type_q};
			REG_GYRO_TYPE:  prdata = {24'd0, gyro_type_q};
			REG_ANGLE_TYPE: prdata = {24'd0, angle_type_q};
			default:        prdata = 32'd0;
		endcase
	end

	// handshake
	assign out_free  = ~out_valid_q | ~out_stall;
	assign move_s1   = v_s1 & out_free;
	assign in_stall  = v_s1 & ~out_free;
	assign in_accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	// framing
	assign is_start   = (rx_byte == start_byte_q);
	assign active_now = is_start | active_q;
	assign base_count = is_start ? '0 : count_q;
	assign base_sum   = is_start ? 8'd0 : sum_q;
	assign is_final   = (base_count == COUNT_W'(PACKET_BYTES - 1));
	assign match      = (rx_byte == base_sum);
	assign load_s1    = in_accept & active_now & is_final & match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= 1'b0;
			sum_q    <= 8'd0;
		end else if (in_accept && active_now) begin
			if (is_final) begin
				count_q  <= '0;
				active_q <= 1'b0;
				sum_q    <= 8'd0;
			end else begin
				count_q  <= base_count + COUNT_W'(1);
				active_q <= 1'b1;
				sum_q    <= base_sum + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && active_now && !is_final) begin
			store_q[base_count[IDX_W-1:0]] <= rx_byte;
		end
	end

	// type decode, accel first then gyro then angle
	always_comb begin
		if (store_q[POS_TYPE] == accel_type_q) begin
			sel_now = SCALE_SEL_ACCEL;
		end else if (store_q[POS_TYPE] == gyro_type_q) begin
			sel_now = SCALE_SEL_GYRO;
		end else if (store_q[POS_TYPE] == angle_type_q) begin
			sel_now = SCALE_SEL_ANGLE;
		end else begin
			sel_now = SCALE_NONE;
		end
	end

	// stage 1: packet fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			type_s1  <= store_q[POS_TYPE];
			sel_s1   <= sel_now;
			raw_x_s1 <= {store_q[POS_X + 1], store_q[POS_X]};
			raw_y_s1 <= {store_q[POS_Y + 1], store_q[POS_Y]};
			raw_z_s1 <= {store_q[POS_Z + 1], store_q[POS_Z]};
			raw_t_s1 <= {store_q[POS_TEMP + 1], store_q[POS_TEMP]};
		end
	end

	// stage 2: scaling
	function automatic logic signed [AXIS_W-1:0] scale_axis(
		input logic signed [RAW_W-1:0] raw,
		input scale_sel_t              sel
	);
		logic signed [AXIS_W-1:0] ext;
		ext = AXIS_W'(raw);
		unique case (sel)
			SCALE_SEL_ACCEL: scale_axis = ext * SCALE_ACCEL;
			SCALE_SEL_GYRO:  scale_axis = ext * SCALE_GYRO;
			SCALE_SEL_ANGLE: scale_axis = ext * SCALE_ANGLE;
			default:         scale_axis = '0;
		endcase
	endfunction

	logic [RAW_W:0]             t_mag;
	logic [TEMP_NUM_W-1:0]      t_num;
	logic [TEMP_NUM_W+31:0]     t_prod;
	logic [QUOT_W-1:0]          t_quot;
	logic signed [TEMP_W-1:0]   t_signed;
	logic signed [TEMP_W-1:0]   t_value;

	always_comb begin
		t_mag    = raw_t_s1[RAW_W-1] ? (RAW_W+1)'(-(RAW_W+1)'(raw_t_s1))
		                             : (RAW_W+1)'(raw_t_s1);
		t_num    = (TEMP_NUM_W'(t_mag) << TEMP_SHIFT) + TEMP_HALF;
		t_prod   = (TEMP_NUM_W+32)'(t_num) * (TEMP_NUM_W+32)'(RECIP_85);
		t_quot   = t_prod[RECIP_SHIFT +: QUOT_W];
		t_signed = raw_t_s1[RAW_W-1] ? -TEMP_W'(signed'({1'b0, t_quot}))
		                             : TEMP_W'(signed'({1'b0, t_quot}));
		t_value  = t_signed + TEMP_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			packet_type <= type_s1;
			axis_x      <= scale_axis(raw_x_s1, sel_s1);
			axis_y      <= scale_axis(raw_y_s1, sel_s1);
			axis_z      <= scale_axis(raw_z_s1, sel_s1);
			temperature <= t_value;
		end
	end

endmodule
